/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tav_pkg.sv */
package tav_pkg;

  // Geometry
  localparam int Axes      = 4;
  localparam int HistDepth = 5;
  localparam int TimeBits  = 32;

  // Field widths
  localparam int AxisW = 2;
  localparam int PosW  = 16;
  localparam int TsW   = 32;
  localparam int VelW  = 16;

  // Arithmetic sizing
  localparam int UsecPerSec = 1000000;
  localparam int UsecW      = 20;
  localparam int MagW       = PosW + 1;
  localparam int ProdW      = MagW + UsecW;
  localparam int StepW      = $clog2(ProdW + 1);

  // History memory sizing
  localparam int SlotW    = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int AxIdxW   = (Axes > 1) ? $clog2(Axes) : 1;
  localparam int MemDepth = Axes * HistDepth;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  // Saturation limits
  localparam logic [ProdW-1:0] PosLimit = ProdW'(2 ** (VelW - 1) - 1);
  localparam logic [ProdW-1:0] NegLimit = ProdW'(2 ** (VelW - 1));
  localparam logic signed [VelW-1:0] VelMaxS = {1'b0, {(VelW - 1){1'b1}}};
  localparam logic signed [VelW-1:0] VelMinS = {1'b1, {(VelW - 1){1'b0}}};

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [AxisW-1:0]       axis;
    logic signed [PosW-1:0] position;
    logic [TsW-1:0]         timestamp;
  } sample_t;

  typedef struct packed {
    logic signed [VelW-1:0] velocity;
    logic                   saturated;
  } result_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos;
    logic [TimeBits-1:0]    ts;
  } hist_t;

  // Flat history address: one row of HistDepth slots per axis
  function automatic logic [AddrW-1:0] mem_addr(input logic [AxisW-1:0] ax,
                                                input logic [SlotW-1:0] slot);
    return AddrW'(int'(ax) * HistDepth + int'(slot));
  endfunction

  function automatic logic axis_ok(input logic [AxisW-1:0] ax);
    return int'(ax) < Axes;
  endfunction

endpackage

/* rtl/touch_axis_velocity.sv */
// Sequence: a moving sample's request is taken, then read, multiply, a 37-step restoring
// divide and finish; a clear item goes straight to finish, the first sample on an axis
// does a five-entry history fill before finish, and equal timestamps skip the divide.
// Flow: sample_stall is high outside idle, so a new request is taken only after the last
// one has finished; finish also waits while an unread result is held by result_stall.
// Reset: rst (synchronous) marks every axis inactive; history memory is not cleared.
`include "assert_macros.svh"

module touch_axis_velocity import tav_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  sample_t sample,
  input  logic    sample_valid,
  output logic    sample_stall,
  output result_t result,
  output logic    result_valid,
  input  logic    result_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t               state;
  sample_t              req;
  logic [Axes-1:0]      active;
  logic [SlotW-1:0]     ptr [Axes];
  logic [SlotW-1:0]     fill_slot;
  logic                 zero_res;
  logic                 neg;
  logic [MagW-1:0]      mag;
  logic [TimeBits-1:0]  dt;
  logic [ProdW-1:0]     quo;
  logic [TimeBits-1:0]  rem;
  logic [StepW-1:0]     step;

  // History memory: circular buffer per axis, ptr marks the oldest slot
  hist_t                mem [MemDepth];
  hist_t                rd_data;
  hist_t                wr_data;
  logic [AddrW-1:0]     rd_addr;
  logic [AddrW-1:0]     wr_addr;
  logic                 wr_en;

  logic                 accept;
  logic [AxIdxW-1:0]    in_ax;
  logic [AxIdxW-1:0]    req_ax;
  logic signed [MagW-1:0] dp;
  logic [TimeBits:0]    rem_sh;
  logic                 rem_ge;
  result_t              result_next;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign in_ax        = AxIdxW'(sample.axis);
  assign req_ax       = AxIdxW'(req.axis);

  // Memory ports
  assign rd_addr = mem_addr(sample.axis, ptr[in_ax]);
  assign wr_en   = (state == ST_FILL) || (state == ST_READ);
  assign wr_addr = (state == ST_FILL) ? mem_addr(req.axis, fill_slot)
                                      : mem_addr(req.axis, ptr[req_ax]);
  assign wr_data = '{pos: req.position, ts: TimeBits'(req.timestamp)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Position difference against the oldest kept sample
  assign dp = $signed({req.position[PosW-1], req.position})
            - $signed({rd_data.pos[PosW-1], rd_data.pos});

  // One restoring divide step
  assign rem_sh = {rem, quo[ProdW-1]};
  assign rem_ge = (rem_sh >= {1'b0, dt});

  // Saturate the quotient to the result width
  always_comb begin
    result_next = '{velocity: '0, saturated: 1'b0};
    if (!zero_res) begin
      if (!neg) begin
        if (quo > PosLimit) begin
          result_next = '{velocity: VelMaxS, saturated: 1'b1};
        end else begin
          result_next.velocity = VelW'(quo[VelW-1:0]);
        end
      end else begin
        if (quo > NegLimit) begin
          result_next = '{velocity: VelMinS, saturated: 1'b1};
        end else begin
          result_next.velocity = VelW'(~quo[VelW-1:0] + 1'b1);
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active       <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < Axes; i++) begin
        ptr[i] <= '0;
      end
    end else begin
      // finish state reloads the output itself when the old result leaves
      if (result_valid && !result_stall && state != ST_FIN) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req <= sample;
            if (sample.cmd == CMD_CLEAR) begin
              active   <= '0;
              zero_res <= 1'b1;
              state    <= ST_FIN;
            end else if (!axis_ok(sample.axis)) begin
              zero_res <= 1'b1;
              state    <= ST_FIN;
            end else if (!active[in_ax]) begin
              active[in_ax] <= 1'b1;
              ptr[in_ax]    <= '0;
              fill_slot     <= '0;
              zero_res      <= 1'b1;
              state         <= ST_FILL;
            end else begin
              zero_res <= 1'b0;
              state    <= ST_READ;
            end
          end
        end
        ST_FILL: begin
          if (fill_slot == SlotW'(HistDepth - 1)) begin
            state <= ST_FIN;
          end else begin
            fill_slot <= fill_slot + 1'b1;
          end
        end
        ST_READ: begin
          // new sample overwrites the oldest slot this cycle
          if (ptr[req_ax] == SlotW'(HistDepth - 1)) begin
            ptr[req_ax] <= '0;
          end else begin
            ptr[req_ax] <= ptr[req_ax] + 1'b1;
          end
          dt    <= TimeBits'(req.timestamp) - rd_data.ts;
          neg   <= dp[MagW-1];
          mag   <= dp[MagW-1] ? MagW'(-dp) : MagW'(dp);
          state <= ST_MUL;
        end
        ST_MUL: begin
          quo  <= ProdW'(mag) * ProdW'(UsecPerSec);
          rem  <= '0;
          step <= StepW'(ProdW - 1);
          if (dt == '0) begin
            zero_res <= 1'b1;
            state    <= ST_FIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_ge ? TimeBits'(rem_sh - {1'b0, dt}) : rem_sh[TimeBits-1:0];
          quo  <= {quo[ProdW-2:0], rem_ge};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!result_valid || !result_stall) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_IMPL(a_sat_at_limit, result_valid && result.saturated, result.velocity == VelMaxS || result.velocity == VelMinS, "saturated result not at a limit")
  `ASSERT_NEXT(a_clear_drops_axes, accept && sample.cmd == CMD_CLEAR, active == '0, "clear left an axis active")
  `ASSERT_NEXT(a_new_axis_fills, accept && sample.cmd == CMD_SAMPLE && axis_ok(sample.axis) && !active[in_ax], state == ST_FILL, "inactive axis skipped history fill")
  `ASSERT_IMPL(a_rem_below_dt, state == ST_DIV, rem < dt, "divider remainder not below divisor")

endmodule
